### design/lvbp_pkg.sv
// Shared types and constants of the length-prefixed value bit packer.
`default_nettype none
package lvbp_pkg;

    localparam int DATA_W  = 32;   // token_count and packed_word width
    localparam int TOTAL_W = 17;   // total_bits width
    localparam int CODE_W  = 64;   // widest code: twice the widest value
    localparam int LEN_W   = 7;    // holds a code length up to CODE_W

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [DATA_W-1:0] token_count;
        logic              end_of_vector;
    } in_word_t;

    typedef struct packed {
        logic [DATA_W-1:0]  packed_word;
        logic               final_word;
        logic [TOTAL_W-1:0] total_bits;
    } out_word_t;

    // One classified item: code top-aligned, its length, end mark, running total.
    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [LEN_W-1:0]   len;
        logic               last;
        logic [TOTAL_W-1:0] total;
    } entry_t;

endpackage
`default_nettype wire

### design/lvbp_front.sv
// Front end: measures each value, builds its code and keeps the running bit total.
`default_nettype none
module lvbp_front #(
    parameter int VALUE_WIDTH  = 32,
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 token_valid,
    input  lvbp_pkg::in_word_t  token,
    input  wire                 q_full,
    output logic                push,
    output lvbp_pkg::entry_t    entry
);
    import lvbp_pkg::*;

    localparam int RAW_LIMIT   = 2 * VALUE_WIDTH * MAX_ELEMENTS;
    localparam int TOTAL_LIMIT = (RAW_LIMIT < int'(TOTAL_MAX)) ? RAW_LIMIT : int'(TOTAL_MAX);
    localparam int NB_W        = $clog2(VALUE_WIDTH + 1);

    logic [TOTAL_W-1:0]     total_reg;
    logic [TOTAL_W-1:0]     total_next;
    logic [VALUE_WIDTH-1:0] value;
    logic [NB_W-1:0]        nbits;
    logic [LEN_W-1:0]       len;
    logic [CODE_W-1:0]      code_raw;
    logic [TOTAL_W:0]       sum;
    logic [TOTAL_W-1:0]     total_sat;

    assign push  = token_valid && !q_full;
    assign value = token.token_count[VALUE_WIDTH-1:0];

    // Bit length of the value, one for zero.
    always_comb
    begin
        nbits = NB_W'(1);
        for (int i = 0; i < VALUE_WIDTH; i++)
        begin
            if (value[i])
            begin
                nbits = NB_W'(i + 1);
            end
        end
    end

    assign len       = LEN_W'({nbits, 1'b0});
    assign code_raw  = CODE_W'(value) | (CODE_W'(1) << nbits);
    assign sum       = {1'b0, total_reg} + (TOTAL_W + 1)'(len);
    assign total_sat = (sum > (TOTAL_W + 1)'(TOTAL_LIMIT)) ? TOTAL_W'(TOTAL_LIMIT)
                                                            : sum[TOTAL_W-1:0];

    always_comb
    begin
        entry.code  = code_raw << (LEN_W'(CODE_W) - len);
        entry.len   = len;
        entry.last  = token.end_of_vector;
        entry.total = total_sat;
    end

    // Restart the total after the vector's last element.
    always_comb
    begin
        total_next = total_reg;
        if (push)
        begin
            total_next = token.end_of_vector ? '0 : total_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

endmodule
`default_nettype wire

### design/lvbp_queue.sv
// Two-entry queue of classified items between front and back.
`default_nettype none
module lvbp_queue (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  lvbp_pkg::entry_t  push_entry,
    input  wire               pop,
    output logic              q_valid,
    output logic              q_full,
    output lvbp_pkg::entry_t  q_entry
);
    import lvbp_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign q_valid = (count_reg != 2'd0);
    assign q_full  = (count_reg == 2'd2);
    assign q_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

### design/lvbp_back.sv
// Back end: appends codes to the bit accumulator and emits full and flushed words.
`default_nettype none
module lvbp_back #(
    parameter int WORD_WIDTH = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 q_valid,
    input  lvbp_pkg::entry_t    q_entry,
    output logic                pop,
    output logic                word_valid,
    input  wire                 word_stall,
    output lvbp_pkg::out_word_t word
);
    import lvbp_pkg::*;

    localparam int AW = WORD_WIDTH + CODE_W;
    localparam int CW = $clog2(AW + 1);

    logic [AW-1:0]          acc_reg;
    logic [AW-1:0]          acc_next;
    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          cnt_next;
    logic                   last_reg;
    logic                   last_next;
    logic [TOTAL_W-1:0]     total_reg;
    logic [TOTAL_W-1:0]     total_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_word_t              out_reg;
    out_word_t              out_next;

    logic [AW-1:0]          code_ext;
    logic [AW-1:0]          cur_acc;
    logic [CW-1:0]          cur_cnt;
    logic                   cur_last;
    logic [TOTAL_W-1:0]     cur_total;
    logic                   out_free;
    logic                   emit_full;
    logic                   emit_flush;
    logic                   emit;
    logic                   is_final;
    logic [WORD_WIDTH-1:0]  top_word;
    logic [WORD_WIDTH+DATA_W-1:0] word_ext;

    // Load the next code as soon as less than one word is buffered and no vector end is pending.
    assign pop      = q_valid && !last_reg && (cnt_reg < CW'(WORD_WIDTH));
    assign code_ext = {q_entry.code, {WORD_WIDTH{1'b0}}};

    always_comb
    begin
        if (pop)
        begin
            cur_acc   = acc_reg | (code_ext >> cnt_reg);
            cur_cnt   = cnt_reg + CW'(q_entry.len);
            cur_last  = q_entry.last;
            cur_total = q_entry.total;
        end
        else
        begin
            cur_acc   = acc_reg;
            cur_cnt   = cnt_reg;
            cur_last  = last_reg;
            cur_total = total_reg;
        end
    end

    assign out_free   = !out_valid_reg || !word_stall;
    assign emit_full  = (cur_cnt >= CW'(WORD_WIDTH));
    assign emit_flush = cur_last && (cur_cnt != '0) && !emit_full;
    assign emit       = out_free && (emit_full || emit_flush);
    assign is_final   = cur_last && (emit_flush || (cur_cnt == CW'(WORD_WIDTH)));
    assign top_word   = cur_acc[AW-1 -: WORD_WIDTH];
    assign word_ext   = {{DATA_W{1'b0}}, top_word};

    always_comb
    begin
        acc_next       = cur_acc;
        cnt_next       = cur_cnt;
        last_next      = cur_last;
        total_next     = cur_total;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && word_stall;
        if (emit)
        begin
            // Drop the emitted word; bits below the fill level are always zero.
            acc_next             = cur_acc << WORD_WIDTH;
            cnt_next             = emit_flush ? '0 : cur_cnt - CW'(WORD_WIDTH);
            out_valid_next       = 1'b1;
            out_next.packed_word = word_ext[DATA_W-1:0];
            out_next.final_word  = is_final;
            out_next.total_bits  = is_final ? cur_total : '0;
            if (is_final)
            begin
                last_next  = 1'b0;
                total_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign word_valid = out_valid_reg;
    assign word       = out_reg;

endmodule
`default_nettype wire

### design/length_prefixed_value_bit_packer.sv
// Top level of the length-prefixed value bit packer.
// An item that completes a word passes the queue slot, then the output register.
// Throughput: one word per cycle at the output while the receiver does not stall; the
// back end takes no new item while a word or more is buffered, draining one word a cycle.
// The front takes one item per cycle while the two-entry queue has room.
// Reset clears the accumulator, the fill count, the running total and all valid flags.
`default_nettype none
module length_prefixed_value_bit_packer #(
    parameter int VALUE_WIDTH  = 32,
    parameter int WORD_WIDTH   = 32,
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 token_valid,
    output logic                token_stall,
    input  lvbp_pkg::in_word_t  token,
    output logic                word_valid,
    input  wire                 word_stall,
    output lvbp_pkg::out_word_t word
);
    import lvbp_pkg::*;

    logic   push;
    logic   pop;
    logic   q_valid;
    logic   q_full;
    entry_t push_entry;
    entry_t q_entry;

    assign token_stall = q_full;

    lvbp_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .token_valid(token_valid),
        .token      (token),
        .q_full     (q_full),
        .push       (push),
        .entry      (push_entry)
    );

    lvbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .q_entry   (q_entry)
    );

    lvbp_back #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .pop       (pop),
        .word_valid(word_valid),
        .word_stall(word_stall),
        .word      (word)
    );

endmodule
`default_nettype wire

### design/lvbp_checker.sv
// Port-level checks of the bit packer, bound to the top level.
`default_nettype none
module lvbp_checker (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 word_valid,
    input  wire                 word_stall,
    input  lvbp_pkg::out_word_t word
);
    import lvbp_pkg::*;

    a_word_held: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word_stall |=> word_valid)
        else $error("stalled word dropped");

    a_word_stable: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word_stall |=> $stable(word))
        else $error("stalled word changed");

    a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word.final_word |-> word.total_bits == '0)
        else $error("total on a non-final word");

    a_total_even: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word.final_word |-> !word.total_bits[0] && word.total_bits != '0)
        else $error("final total not a positive even count");

endmodule

bind length_prefixed_value_bit_packer lvbp_checker u_lvbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .word_valid(word_valid),
    .word_stall(word_stall),
    .word      (word)
);
`default_nettype wire

### sim/tb_length_prefixed_value_bit_packer.sv
// Self-checking testbench for the length-prefixed value bit packer.
`timescale 1ns / 100ps
module tb_length_prefixed_value_bit_packer;
    import lvbp_pkg::*;

    localparam int VALUE_W       = 32;
    localparam int WORD_W        = 32;
    localparam int MAX_ELEM      = 1024;
    localparam int TOTAL_LIMIT   = (2 * VALUE_W * MAX_ELEM < 131071) ?
                                   2 * VALUE_W * MAX_ELEM : 131071;
    localparam int LONG_TOKENS   = 60;
    localparam int RANDOM_TOKENS = 127;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [31:0] value;
        logic        eov;
        logic [1:0]  typed_cnt;
        out_word_t   first;
        out_word_t   second;
    } dir_row_t;

    localparam out_word_t NO_WORD = '0;
    localparam int DIR_ROWS = 23;

    // Fresh-vector rows first so their words can be typed in directly.
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{32'h0000_0000, 1'b1, 2'd1, '{32'h8000_0000, 1'b1, 17'd2}, NO_WORD},
        '{32'h0000_0001, 1'b1, 2'd1, '{32'hC000_0000, 1'b1, 17'd2}, NO_WORD},
        '{32'h0000_0002, 1'b1, 2'd1, '{32'h6000_0000, 1'b1, 17'd4}, NO_WORD},
        '{32'hFFFF_FFFF, 1'b1, 2'd2, '{32'h0000_0001, 1'b0, 17'd0},
                                     '{32'hFFFF_FFFF, 1'b1, 17'd64}},
        '{32'h8000_0000, 1'b1, 2'd2, '{32'h0000_0001, 1'b0, 17'd0},
                                     '{32'h8000_0000, 1'b1, 17'd64}},
        // widest code straddling two boundaries, so it spans three words, then flush
        '{32'h0000_0005, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{32'h0000_0000, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{32'h7FFF_FFFF, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{32'h0000_0003, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{32'hFFFF_FFFF, 1'b1, 2'd0, NO_WORD, NO_WORD},
        '{32'h1234_5678, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{32'h0000_FFFF, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{32'hAAAA_AAAA, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{32'h5555_5555, 1'b1, 2'd0, NO_WORD, NO_WORD},
        // vector ending exactly on a word boundary: no padding word
        '{32'h0000_0001, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{32'h0000_0001, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{32'h0000_0001, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{32'h0000_0001, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{32'h0000_0001, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{32'h0000_0001, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{32'h0000_0001, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{32'h0000_0001, 1'b0, 2'd0, NO_WORD, NO_WORD},
        '{32'h0000_00FF, 1'b1, 2'd0, NO_WORD, NO_WORD}
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      token_valid = 1'b0;
    logic      token_stall;
    in_word_t  token = '0;
    logic      word_valid;
    logic      word_stall = 1'b0;
    out_word_t word;

    length_prefixed_value_bit_packer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token       (token),
        .word_valid  (word_valid),
        .word_stall  (word_stall),
        .word        (word)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [WORD_W-1:0] fill_word = '0;
    int                free_bits = WORD_W;
    int                vec_bits = 0;
    out_word_t         expected_words [$];

    int errors = 0;
    int words_checked = 0;
    int tokens_packed = 0;
    int vectors_closed = 0;
    int burst_left = 0;
    int cyc = 0;
    int hold_left = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    out_word_t want;

    task automatic pack_token(input in_word_t t, input bit record);
        logic [63:0] code;
        out_word_t   w;
        int          n;
        int          i;
        int          made;
        n = 1;
        made = 0;
        for (i = 1; i < VALUE_W; i++)
            if (t.token_count[i])
                n = i + 1;
        code = {32'd0, t.token_count} | (64'd1 << n);
        for (i = 2 * n - 1; i >= 0; i--)
        begin
            fill_word[free_bits - 1] = code[i];
            free_bits--;
            if (free_bits == 0)
            begin
                w.packed_word = fill_word;
                w.final_word = 1'b0;
                w.total_bits = '0;
                if (record)
                    expected_words.push_back(w);
                made++;
                fill_word = '0;
                free_bits = WORD_W;
            end
        end
        vec_bits += 2 * n;
        if (vec_bits > TOTAL_LIMIT)
            vec_bits = TOTAL_LIMIT;
        if (t.end_of_vector)
        begin
            // flush the partial word, then tag the vector's last word
            if (free_bits < WORD_W)
            begin
                w.packed_word = fill_word;
                w.final_word = 1'b0;
                w.total_bits = '0;
                if (record)
                    expected_words.push_back(w);
                made++;
            end
            if (made > 0 && record)
            begin
                w = expected_words.pop_back();
                w.final_word = 1'b1;
                w.total_bits = vec_bits[TOTAL_W-1:0];
                expected_words.push_back(w);
            end
            vectors_closed++;
            fill_word = '0;
            free_bits = WORD_W;
            vec_bits = 0;
        end
        tokens_packed++;
    endtask

    task automatic offer_token(input logic [31:0] value, input logic eov, input bit record);
        in_word_t t;
        t.token_count = value;
        t.end_of_vector = eov;
        if (burst_left == 0)
        begin
            token_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        token <= t;
        token_valid <= 1'b1;
        @(posedge clk);
        while (token_stall)
            @(posedge clk);
        burst_left--;
        pack_token(t, record);
    endtask

    // Receiver: rotates through four stall patterns; one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            word_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            word_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            case ((cyc / 97) % 4)
                0: word_stall <= 1'b0;
                1: word_stall <= ($urandom_range(0, 99) < 30);
                2: word_stall <= ($urandom_range(0, 99) < 70);
                default: word_stall <= cyc[0];
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && word_valid && !word_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual %h/%b/%0d", $time,
                         word.packed_word, word.final_word, word.total_bits);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (word.packed_word !== want.packed_word)
                begin
                    $display("%0t: packed_word expected %h actual %h", $time,
                             want.packed_word, word.packed_word);
                    errors++;
                end
                if (word.final_word !== want.final_word)
                begin
                    $display("%0t: final_word expected %b actual %b", $time,
                             want.final_word, word.final_word);
                    errors++;
                end
                if (word.total_bits !== want.total_bits)
                begin
                    $display("%0t: total_bits expected %0d actual %0d", $time,
                             want.total_bits, word.total_bits);
                    errors++;
                end
                words_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cyc,
                     expected_words.size());
            $display("length_prefixed_value_bit_packer test failed");
            $finish;
        end
    end

    initial
    begin
        int          r;
        int          k;
        int          vec_len;
        int          sent;
        logic [31:0] value;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIR_ROWS; r++)
        begin
            if (DIRECTED[r].typed_cnt > 0)
                expected_words.push_back(DIRECTED[r].first);
            if (DIRECTED[r].typed_cnt > 1)
                expected_words.push_back(DIRECTED[r].second);
            offer_token(DIRECTED[r].value, DIRECTED[r].eov, DIRECTED[r].typed_cnt == 0);
        end

        // One long vector of widest codes; the receiver holds off at its start
        // so the packer backs up.
        hold_req <= 1'b1;
        for (k = 0; k < LONG_TOKENS; k++)
        begin
            value = {1'b1, 31'($urandom())};
            offer_token(value, k == LONG_TOKENS - 1, 1'b1);
        end

        sent = 0;
        while (sent < RANDOM_TOKENS)
        begin
            vec_len = $urandom_range(1, 12);
            for (k = 0; k < vec_len && sent < RANDOM_TOKENS; k++)
            begin
                case ($urandom_range(0, 5))
                    0: value = '0;
                    1: value = '1;
                    2: value = $urandom_range(0, 7);
                    3: value = $urandom() >> $urandom_range(0, 31);
                    4: value = 32'd1 << $urandom_range(0, 31);
                    default: value = $urandom();
                endcase
                offer_token(value, (k == vec_len - 1) || (sent == RANDOM_TOKENS - 1), 1'b1);
                sent++;
            end
        end
        token_valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d tokens in %0d vectors packed, %0d words checked", tokens_packed,
                 vectors_closed, words_checked);
        $display("a vector of %0d widest codes met a %0d-cycle receiver hold-off",
                 LONG_TOKENS, HOLD_CYCLES);
        if (errors == 0)
            $display("length_prefixed_value_bit_packer test passed");
        else
            $display("length_prefixed_value_bit_packer test failed");
        $finish;
    end

endmodule

### files.f
design/lvbp_pkg.sv
design/lvbp_front.sv
design/lvbp_queue.sv
design/lvbp_back.sv
design/length_prefixed_value_bit_packer.sv
design/lvbp_checker.sv
sim/tb_length_prefixed_value_bit_packer.sv
